[hdl/lkerl_pkg.sv]
// Package for the LRU keyed event rate limiter: default sizes, the scan
// record that runs along the cell chain, the update command and the FSM states.
// No dependencies.
`default_nettype none

package lkerl_pkg;

  localparam int LKERL_TABLE_ENTRIES = 64;
  localparam int LKERL_KEY_BITS      = 32;
  localparam int LKERL_TIME_BITS     = 48;

  // Index and rank fields are sized for the largest table (256 entries).
  localparam int LKERL_IDX_W  = 8;
  localparam int LKERL_TIME_W = 64;
  localparam int LKERL_CNT_W  = 32;
  localparam int LKERL_CODE_W = 40;
  localparam int LKERL_WIN_W  = 32;

  localparam logic [LKERL_CNT_W-1:0] LKERL_CNT_MAX = '1;
  localparam logic [LKERL_WIN_W-1:0] LKERL_WINDOW_RESET = 32'd60000;

  // Register word addresses on the configuration port.
  localparam logic LKERL_REG_WINDOW = 1'b0;

  typedef struct packed {
    logic                    hit;
    logic [LKERL_IDX_W-1:0]  hit_idx;
    logic [LKERL_IDX_W-1:0]  hit_rank;
    logic [LKERL_TIME_W-1:0] hit_last;
    logic [LKERL_CNT_W-1:0]  hit_supp;
    logic                    free;
    logic [LKERL_IDX_W-1:0]  free_idx;
    logic [LKERL_IDX_W-1:0]  worst_rank;
    logic [LKERL_IDX_W-1:0]  worst_idx;
  } lkerl_scan_t;

  typedef struct packed {
    logic                    en;
    logic                    age_all;
    logic [LKERL_IDX_W-1:0]  limit;
    logic [LKERL_IDX_W-1:0]  slot;
    logic [LKERL_TIME_W-1:0] last;
    logic [LKERL_CNT_W-1:0]  supp;
  } lkerl_upd_t;

  typedef enum logic [2:0] {
    LKERL_IDLE,
    LKERL_SCAN,
    LKERL_DECIDE,
    LKERL_UPDATE,
    LKERL_PUSH
  } lkerl_state_t;

endpackage

`default_nettype wire

[hdl/lkerl_cell.sv]
// One table entry of the rate limiter: key, last report time, suppressed
// count and recency rank, plus one stage of the lookup scan. Uses lkerl_pkg.
`default_nettype none

module lkerl_cell
  import lkerl_pkg::*;
#(
  parameter int IDX           = 0,
  parameter int TABLE_ENTRIES = LKERL_TABLE_ENTRIES,
  parameter int KEY_BITS      = LKERL_KEY_BITS,
  parameter int TIME_BITS     = LKERL_TIME_BITS
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic [KEY_BITS-1:0] key_i,
  input  wire lkerl_scan_t         scan_i,
  output lkerl_scan_t              scan_o,
  input  wire lkerl_upd_t          upd_i
);

  localparam int RANK_W = (TABLE_ENTRIES > 2) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [LKERL_IDX_W-1:0] MY_IDX = LKERL_IDX_W'(IDX);

  logic                   valid_r, valid_nxt;
  logic [KEY_BITS-1:0]    key_r, key_nxt;
  logic [TIME_BITS-1:0]   last_r, last_nxt;
  logic [LKERL_CNT_W-1:0] supp_r, supp_nxt;
  logic [RANK_W-1:0]      rank_r, rank_nxt;
  lkerl_scan_t            scan_r, scan_nxt;
  logic [LKERL_IDX_W-1:0] rank_ext;

  assign rank_ext = LKERL_IDX_W'(rank_r);
  assign scan_o   = scan_r;

  // Fold this entry into the scan record handed on to the next cell.
  always_comb begin
    scan_nxt = scan_i;
    if (!scan_i.hit && valid_r && (key_r == key_i)) begin
      scan_nxt.hit      = 1'b1;
      scan_nxt.hit_idx  = MY_IDX;
      scan_nxt.hit_rank = rank_ext;
      scan_nxt.hit_last = LKERL_TIME_W'(last_r);
      scan_nxt.hit_supp = supp_r;
    end
    if (!scan_i.free && !valid_r) begin
      scan_nxt.free     = 1'b1;
      scan_nxt.free_idx = MY_IDX;
    end
    if (rank_ext > scan_i.worst_rank) begin
      scan_nxt.worst_rank = rank_ext;
      scan_nxt.worst_idx  = MY_IDX;
    end
  end

  // Age newer entries (or all), then overwrite the chosen slot as newest.
  always_comb begin
    valid_nxt = valid_r;
    key_nxt   = key_r;
    last_nxt  = last_r;
    supp_nxt  = supp_r;
    rank_nxt  = rank_r;
    if (upd_i.en) begin
      if (valid_r && (upd_i.age_all || (rank_ext < upd_i.limit))) begin
        rank_nxt = rank_r + RANK_W'(1);
      end
      if (upd_i.slot == MY_IDX) begin
        valid_nxt = 1'b1;
        key_nxt   = key_i;
        last_nxt  = TIME_BITS'(upd_i.last);
        supp_nxt  = upd_i.supp;
        rank_nxt  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r  <= key_nxt;
    last_r <= last_nxt;
    supp_r <= supp_nxt;
    rank_r <= rank_nxt;
    scan_r <= scan_nxt;
  end

endmodule

`default_nettype wire

[hdl/lru_keyed_event_rate_limiter.sv]
// LRU keyed event rate limiter, top level.
// Uses lkerl_pkg and a chain of lkerl_cell entries.
//
// Usage:
//   Input requests (in_valid / in_stall) carry an event key, a 40-bit code,
//   a timestamp and a log_ready flag. Each request yields exactly one result
//   on out_valid / out_stall: emit, the event count and the echoed key and
//   code. emit is set for a new key or when window_ticks have passed since
//   the key's last report; otherwise the key's suppressed count advances.
//   A request with log_ready low changes nothing; it skips the scan and goes
//   straight to the PUSH state, which loads its result.
//   Otherwise the lookup scan walks the cell chain one entry per cycle, then
//   the DECIDE, UPDATE and PUSH states follow; the next request can be
//   accepted once the block is back in IDLE. The scan length sets the rate,
//   one request at a time.
//   in_stall is high while a request is in flight. A finished result waits
//   in the output register while out_stall is high; the next request can be
//   accepted meanwhile, but its result holds until the register drains.
//   window_ticks is written over the APB-style port at word address 0
//   (reset 60000); write it only while the block is idle.
//   Reset is synchronous, active low: it empties the table and the output
//   register; no clearing pass is needed.
`default_nettype none

module lru_keyed_event_rate_limiter
  import lkerl_pkg::*;
#(
  parameter int TABLE_ENTRIES = LKERL_TABLE_ENTRIES,
  parameter int KEY_BITS      = LKERL_KEY_BITS,
  parameter int TIME_BITS     = LKERL_TIME_BITS
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  // input requests
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic [KEY_BITS-1:0]     in_event_key,
  input  wire logic [LKERL_CODE_W-1:0] in_sql_state,
  input  wire logic [TIME_BITS-1:0]    in_now_ticks,
  input  wire logic                    in_log_ready,
  // results
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic                         out_emit,
  output logic [LKERL_CNT_W-1:0]       out_event_count,
  output logic [KEY_BITS-1:0]          out_report_key,
  output logic [LKERL_CODE_W-1:0]      out_report_code,
  // configuration
  input  wire logic                    psel,
  input  wire logic                    penable,
  input  wire logic                    pwrite,
  input  wire logic [2:0]              paddr,
  input  wire logic [LKERL_WIN_W-1:0]  pwdata,
  output logic [LKERL_WIN_W-1:0]       prdata,
  output logic                         pready
);

  localparam int CNT_W = (TABLE_ENTRIES > 2) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [CNT_W-1:0] LAST_CELL = CNT_W'(TABLE_ENTRIES - 1);
  localparam int CMP_W = (TIME_BITS > LKERL_WIN_W) ? TIME_BITS : LKERL_WIN_W;

  lkerl_state_t state_r, state_nxt;

  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [LKERL_WIN_W-1:0]  window_r, window_nxt;
  logic [KEY_BITS-1:0]     key_r, key_nxt;
  logic [LKERL_CODE_W-1:0] code_r, code_nxt;
  logic [TIME_BITS-1:0]    now_r, now_nxt;
  lkerl_upd_t              upd_r, upd_nxt, upd_bus;
  logic                    res_emit_r, res_emit_nxt;
  logic [LKERL_CNT_W-1:0]  res_cnt_r, res_cnt_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic                    out_emit_r, out_emit_nxt;
  logic [LKERL_CNT_W-1:0]  out_cnt_r, out_cnt_nxt;
  logic [KEY_BITS-1:0]     out_key_r, out_key_nxt;
  logic [LKERL_CODE_W-1:0] out_code_r, out_code_nxt;

  logic accept;
  logic cfg_wr;
  logic out_free;
  logic load_out;
  logic upd_en;

  lkerl_scan_t scan_w [0:TABLE_ENTRIES];
  lkerl_scan_t scan_end;

  // decision datapath
  logic                    fresh;
  logic [LKERL_IDX_W-1:0]  dec_slot;
  logic [LKERL_IDX_W-1:0]  dec_limit;
  logic                    dec_age_all;
  logic [TIME_BITS-1:0]    dec_last;
  logic [LKERL_CNT_W-1:0]  dec_supp;
  logic [TIME_BITS-1:0]    age_ticks;
  logic                    elapsed;
  logic                    dec_emit;
  logic [LKERL_CNT_W-1:0]  sat_inc;

  assign accept   = in_valid && !in_stall;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign out_free = !out_valid_r || !out_stall;
  assign pready   = 1'b1;
  assign prdata   = (paddr[2] == LKERL_REG_WINDOW) ? window_r : '0;

  // ---------------------------------------------------------------------
  // Cell chain
  // ---------------------------------------------------------------------
  assign scan_w[0] = '0;
  assign scan_end  = scan_w[TABLE_ENTRIES];

  always_comb begin
    upd_bus    = upd_r;
    upd_bus.en = upd_en;
  end

  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    lkerl_cell #(
      .IDX           (g),
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .KEY_BITS      (KEY_BITS),
      .TIME_BITS     (TIME_BITS)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .key_i  (key_r),
      .scan_i (scan_w[g]),
      .scan_o (scan_w[g+1]),
      .upd_i  (upd_bus)
    );
  end

  // ---------------------------------------------------------------------
  // Decision on the finished scan
  // ---------------------------------------------------------------------
  always_comb begin
    fresh       = 1'b1;
    dec_slot    = scan_end.worst_idx;
    dec_limit   = scan_end.worst_rank;
    dec_age_all = 1'b0;
    dec_last    = '0;
    dec_supp    = '0;
    if (scan_end.hit) begin
      fresh     = 1'b0;
      dec_slot  = scan_end.hit_idx;
      dec_limit = scan_end.hit_rank;
      dec_last  = TIME_BITS'(scan_end.hit_last);
      dec_supp  = scan_end.hit_supp;
    end else if (scan_end.free) begin
      dec_slot    = scan_end.free_idx;
      dec_age_all = 1'b1;
    end
  end

  assign age_ticks = now_r - dec_last;
  assign elapsed   = CMP_W'(age_ticks) >= CMP_W'(window_r);
  assign dec_emit  = fresh || elapsed;
  assign sat_inc   = (dec_supp == LKERL_CNT_MAX) ? LKERL_CNT_MAX
                                                 : dec_supp + LKERL_CNT_W'(1);

  // ---------------------------------------------------------------------
  // Control FSM
  // ---------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      LKERL_IDLE: begin
        if (accept) begin
          state_nxt = in_log_ready ? LKERL_SCAN : LKERL_PUSH;
        end
      end
      LKERL_SCAN: begin
        if (cnt_r == LAST_CELL) begin
          state_nxt = LKERL_DECIDE;
        end
      end
      LKERL_DECIDE: state_nxt = LKERL_UPDATE;
      LKERL_UPDATE: state_nxt = LKERL_PUSH;
      LKERL_PUSH: begin
        if (out_free) begin
          state_nxt = LKERL_IDLE;
        end
      end
      default: state_nxt = LKERL_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    upd_en   = 1'b0;
    load_out = 1'b0;
    case (state_r)
      LKERL_IDLE:   in_stall = 1'b0;
      LKERL_SCAN:   in_stall = 1'b1;
      LKERL_DECIDE: in_stall = 1'b1;
      LKERL_UPDATE: upd_en   = 1'b1;
      LKERL_PUSH:   load_out = out_free;
      default:      in_stall = 1'b1;
    endcase
  end

  // ---------------------------------------------------------------------
  // Datapath next values
  // ---------------------------------------------------------------------
  always_comb begin
    cnt_nxt      = cnt_r;
    key_nxt      = key_r;
    code_nxt     = code_r;
    now_nxt      = now_r;
    upd_nxt      = upd_r;
    res_emit_nxt = res_emit_r;
    res_cnt_nxt  = res_cnt_r;
    window_nxt   = window_r;

    if (cfg_wr && (paddr[2] == LKERL_REG_WINDOW)) begin
      window_nxt = pwdata;
    end

    if (accept) begin
      cnt_nxt      = '0;
      key_nxt      = in_event_key;
      code_nxt     = in_sql_state;
      now_nxt      = in_now_ticks;
      res_emit_nxt = 1'b0;
      res_cnt_nxt  = '0;
    end else if (state_r == LKERL_SCAN) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end

    if (state_r == LKERL_DECIDE) begin
      upd_nxt.en      = 1'b0;
      upd_nxt.age_all = dec_age_all;
      upd_nxt.limit   = dec_limit;
      upd_nxt.slot    = dec_slot;
      upd_nxt.last    = LKERL_TIME_W'(dec_emit ? now_r : dec_last);
      upd_nxt.supp    = dec_emit ? '0 : sat_inc;
      res_emit_nxt    = dec_emit;
      res_cnt_nxt     = dec_emit ? sat_inc : '0;
    end
  end

  // Output register: drop the held result when taken, load a new one when free.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_emit_nxt  = out_emit_r;
    out_cnt_nxt   = out_cnt_r;
    out_key_nxt   = out_key_r;
    out_code_nxt  = out_code_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (load_out) begin
      out_valid_nxt = 1'b1;
      out_emit_nxt  = res_emit_r;
      out_cnt_nxt   = res_cnt_r;
      out_key_nxt   = key_r;
      out_code_nxt  = code_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= LKERL_IDLE;
      window_r    <= LKERL_WINDOW_RESET;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      window_r    <= window_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r      <= key_nxt;
    code_r     <= code_nxt;
    now_r      <= now_nxt;
    upd_r      <= upd_nxt;
    res_emit_r <= res_emit_nxt;
    res_cnt_r  <= res_cnt_nxt;
    out_emit_r <= out_emit_nxt;
    out_cnt_r  <= out_cnt_nxt;
    out_key_r  <= out_key_nxt;
    out_code_r <= out_code_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_emit        = out_emit_r;
  assign out_event_count = out_cnt_r;
  assign out_report_key  = out_key_r;
  assign out_report_code = out_code_r;

endmodule

`default_nettype wire

[hdl/lkerl_checker.sv]
// Port-level checks for the LRU keyed event rate limiter, bound to the top
// level. Uses lkerl_pkg.
`default_nettype none

module lkerl_checker
  import lkerl_pkg::*;
#(
  parameter int KEY_BITS = LKERL_KEY_BITS
) (
  input wire logic                    clk,
  input wire logic                    rst_n,
  input wire logic                    in_valid,
  input wire logic                    in_stall,
  input wire logic                    out_valid,
  input wire logic                    out_stall,
  input wire logic                    out_emit,
  input wire logic [LKERL_CNT_W-1:0]  out_event_count,
  input wire logic [KEY_BITS-1:0]     out_report_key
);

  // A stalled result stays in place.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_report_key)))
    else $error("stalled result changed or dropped");

  // A suppressed event reports no count.
  a_no_emit_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_emit) |-> (out_event_count == '0))
    else $error("count reported without emit");

  // A report always counts at least the current event.
  a_emit_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_emit) |-> (out_event_count != '0))
    else $error("emit with zero count");

  // One request at a time: after an accept the input side stalls.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted while one is in flight");

endmodule

bind lru_keyed_event_rate_limiter lkerl_checker #(
  .KEY_BITS (KEY_BITS)
) u_lkerl_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_emit        (out_emit),
  .out_event_count (out_event_count),
  .out_report_key  (out_report_key)
);

`default_nettype wire
